FILE: design/bsopd_pkg.sv
// Package for the byte stream opcode predecoder.
// Holds the mnemonic and addressing mode codes and the fixed opcode table.
// No dependencies; used by byte_stream_opcode_predecoder_top.
`default_nettype none

package bsopd_pkg;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MnW    = 6;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned LenW   = 2;

  typedef enum logic [MnW-1:0] {
    MN_ILL, MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI,
    MN_BNE, MN_BPL, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI,
    MN_CLV, MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR,
    MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
    MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_ROL,
    MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC, MN_SED, MN_SEI, MN_STA,
    MN_STX, MN_STY, MN_TAX, MN_TAY, MN_TSX, MN_TXA, MN_TXS, MN_TYA
  } mn_t;

  typedef enum logic [ModeW-1:0] {
    AM_NONE, AM_ACC, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_INDX, AM_INDY,
    AM_REL, AM_ABS, AM_ABSX, AM_ABSY, AM_IND
  } am_t;

  localparam logic [LenW-1:0] LEN_1 = 2'd1;
  localparam logic [LenW-1:0] LEN_2 = 2'd2;
  localparam logic [LenW-1:0] LEN_3 = 2'd3;

  typedef enum logic [1:0] {
    IDX_OPCODE = 2'd0,
    IDX_LOW    = 2'd1,
    IDX_HIGH   = 2'd2,
    IDX_STRAY  = 2'd3
  } idx_t;

  typedef struct packed {
    mn_t mn;
    am_t am;
  } op_info_t;

  function automatic logic [LenW-1:0] len_of(input am_t am);
    logic [LenW-1:0] len;
    if (am < AM_IMM) begin
      len = LEN_1;
    end else if (am < AM_ABS) begin
      len = LEN_2;
    end else begin
      len = LEN_3;
    end
    return len;
  endfunction

  function automatic op_info_t op_lookup(input logic [ByteW-1:0] op);
    op_info_t e;
    unique case (op)
      8'h00: e = '{MN_BRK, AM_NONE};
      8'h01: e = '{MN_ORA, AM_INDX};
      8'h05: e = '{MN_ORA, AM_ZP};
      8'h06: e = '{MN_ASL, AM_ZP};
      8'h08: e = '{MN_PHP, AM_NONE};
      8'h09: e = '{MN_ORA, AM_IMM};
      8'h0A: e = '{MN_ASL, AM_ACC};
      8'h0D: e = '{MN_ORA, AM_ABS};
      8'h0E: e = '{MN_ASL, AM_ABS};
      8'h10: e = '{MN_BPL, AM_REL};
      8'h11: e = '{MN_ORA, AM_INDY};
      8'h15: e = '{MN_ORA, AM_ZPX};
      8'h16: e = '{MN_ASL, AM_ZPX};
      8'h18: e = '{MN_CLC, AM_NONE};
      8'h19: e = '{MN_ORA, AM_ABSY};
      8'h1D: e = '{MN_ORA, AM_ABSX};
      8'h1E: e = '{MN_ASL, AM_ABSX};
      8'h20: e = '{MN_JSR, AM_ABS};
      8'h21: e = '{MN_AND, AM_INDX};
      8'h24: e = '{MN_BIT, AM_ZP};
      8'h25: e = '{MN_AND, AM_ZP};
      8'h26: e = '{MN_ROL, AM_ZP};
      8'h28: e = '{MN_PLP, AM_NONE};
      8'h29: e = '{MN_AND, AM_IMM};
      8'h2A: e = '{MN_ROL, AM_ACC};
      8'h2C: e = '{MN_BIT, AM_ABS};
      8'h2D: e = '{MN_AND, AM_ABS};
      8'h2E: e = '{MN_ROL, AM_ABS};
      8'h30: e = '{MN_BMI, AM_REL};
      8'h31: e = '{MN_AND, AM_INDY};
      8'h35: e = '{MN_AND, AM_ZPX};
      8'h36: e = '{MN_ROL, AM_ZPX};
      8'h38: e = '{MN_SEC, AM_NONE};
      8'h39: e = '{MN_AND, AM_ABSY};
      8'h3D: e = '{MN_AND, AM_ABSX};
      8'h3E: e = '{MN_ROL, AM_ABSX};
      8'h40: e = '{MN_RTI, AM_NONE};
      8'h41: e = '{MN_EOR, AM_INDX};
      8'h45: e = '{MN_EOR, AM_ZP};
      8'h46: e = '{MN_LSR, AM_ZP};
      8'h48: e = '{MN_PHA, AM_NONE};
      8'h49: e = '{MN_EOR, AM_IMM};
      8'h4A: e = '{MN_LSR, AM_ACC};
      8'h4C: e = '{MN_JMP, AM_ABS};
      8'h4D: e = '{MN_EOR, AM_ABS};
      8'h4E: e = '{MN_LSR, AM_ABS};
      8'h50: e = '{MN_BVC, AM_REL};
      8'h51: e = '{MN_EOR, AM_INDY};
      8'h55: e = '{MN_EOR, AM_ZPX};
      8'h56: e = '{MN_LSR, AM_ZPX};
      8'h58: e = '{MN_CLI, AM_NONE};
      8'h59: e = '{MN_EOR, AM_ABSY};
      8'h5D: e = '{MN_EOR, AM_ABSX};
      8'h5E: e = '{MN_LSR, AM_ABSX};
      8'h60: e = '{MN_RTS, AM_NONE};
      8'h61: e = '{MN_ADC, AM_INDX};
      8'h65: e = '{MN_ADC, AM_ZP};
      8'h66: e = '{MN_ROR, AM_ZP};
      8'h68: e = '{MN_PLA, AM_NONE};
      8'h69: e = '{MN_ADC, AM_IMM};
      8'h6A: e = '{MN_ROR, AM_ACC};
      8'h6C: e = '{MN_JMP, AM_IND};
      8'h6D: e = '{MN_ADC, AM_ABS};
      8'h6E: e = '{MN_ROR, AM_ABS};
      8'h70: e = '{MN_BVS, AM_REL};
      8'h71: e = '{MN_ADC, AM_INDY};
      8'h75: e = '{MN_ADC, AM_ZPX};
      8'h76: e = '{MN_ROR, AM_ZPX};
      8'h78: e = '{MN_SEI, AM_NONE};
      8'h79: e = '{MN_ADC, AM_ABSY};
      8'h7D: e = '{MN_ADC, AM_ABSX};
      8'h7E: e = '{MN_ROR, AM_ABSX};
      8'h81: e = '{MN_STA, AM_INDX};
      8'h84: e = '{MN_STY, AM_ZP};
      8'h85: e = '{MN_STA, AM_ZP};
      8'h86: e = '{MN_STX, AM_ZP};
      8'h88: e = '{MN_DEY, AM_NONE};
      8'h8A: e = '{MN_TXA, AM_NONE};
      8'h8C: e = '{MN_STY, AM_ABS};
      8'h8D: e = '{MN_STA, AM_ABS};
      8'h8E: e = '{MN_STX, AM_ABS};
      8'h90: e = '{MN_BCC, AM_REL};
      8'h91: e = '{MN_STA, AM_INDY};
      8'h94: e = '{MN_STY, AM_ZPX};
      8'h95: e = '{MN_STA, AM_ZPX};
      8'h96: e = '{MN_STX, AM_ZPY};
      8'h98: e = '{MN_TYA, AM_NONE};
      8'h99: e = '{MN_STA, AM_ABSY};
      8'h9A: e = '{MN_TXS, AM_NONE};
      8'h9D: e = '{MN_STA, AM_ABSX};
      8'hA0: e = '{MN_LDY, AM_IMM};
      8'hA1: e = '{MN_LDA, AM_INDX};
      8'hA2: e = '{MN_LDX, AM_IMM};
      8'hA4: e = '{MN_LDY, AM_ZP};
      8'hA5: e = '{MN_LDA, AM_ZP};
      8'hA6: e = '{MN_LDX, AM_ZP};
      8'hA8: e = '{MN_TAY, AM_NONE};
      8'hA9: e = '{MN_LDA, AM_IMM};
      8'hAA: e = '{MN_TAX, AM_NONE};
      8'hAC: e = '{MN_LDY, AM_ABS};
      8'hAD: e = '{MN_LDA, AM_ABS};
      8'hAE: e = '{MN_LDX, AM_ABS};
      8'hB0: e = '{MN_BCS, AM_REL};
      8'hB1: e = '{MN_LDA, AM_INDY};
      8'hB4: e = '{MN_LDY, AM_ZPX};
      8'hB5: e = '{MN_LDA, AM_ZPX};
      8'hB6: e = '{MN_LDX, AM_ZPY};
      8'hB8: e = '{MN_CLV, AM_NONE};
      8'hB9: e = '{MN_LDA, AM_ABSY};
      8'hBA: e = '{MN_TSX, AM_NONE};
      8'hBC: e = '{MN_LDY, AM_ABSX};
      8'hBD: e = '{MN_LDA, AM_ABSX};
      8'hBE: e = '{MN_LDX, AM_ABSY};
      8'hC0: e = '{MN_CPY, AM_IMM};
      8'hC1: e = '{MN_CMP, AM_INDX};
      8'hC4: e = '{MN_CPY, AM_ZP};
      8'hC5: e = '{MN_CMP, AM_ZP};
      8'hC6: e = '{MN_DEC, AM_ZP};
      8'hC8: e = '{MN_INY, AM_NONE};
      8'hC9: e = '{MN_CMP, AM_IMM};
      8'hCA: e = '{MN_DEX, AM_NONE};
      8'hCC: e = '{MN_CPY, AM_ABS};
      8'hCD: e = '{MN_CMP, AM_ABS};
      8'hCE: e = '{MN_DEC, AM_ABS};
      8'hD0: e = '{MN_BNE, AM_REL};
      8'hD1: e = '{MN_CMP, AM_INDY};
      8'hD5: e = '{MN_CMP, AM_ZPX};
      8'hD6: e = '{MN_DEC, AM_ZPX};
      8'hD8: e = '{MN_CLD, AM_NONE};
      8'hD9: e = '{MN_CMP, AM_ABSY};
      8'hDD: e = '{MN_CMP, AM_ABSX};
      8'hDE: e = '{MN_DEC, AM_ABSX};
      8'hE0: e = '{MN_CPX, AM_IMM};
      8'hE1: e = '{MN_SBC, AM_INDX};
      8'hE4: e = '{MN_CPX, AM_ZP};
      8'hE5: e = '{MN_SBC, AM_ZP};
      8'hE6: e = '{MN_INC, AM_ZP};
      8'hE8: e = '{MN_INX, AM_NONE};
      8'hE9: e = '{MN_SBC, AM_IMM};
      8'hEA: e = '{MN_NOP, AM_NONE};
      8'hEC: e = '{MN_CPX, AM_ABS};
      8'hED: e = '{MN_SBC, AM_ABS};
      8'hEE: e = '{MN_INC, AM_ABS};
      8'hF0: e = '{MN_BEQ, AM_REL};
      8'hF1: e = '{MN_SBC, AM_INDY};
      8'hF5: e = '{MN_SBC, AM_ZPX};
      8'hF6: e = '{MN_INC, AM_ZPX};
      8'hF8: e = '{MN_SED, AM_NONE};
      8'hF9: e = '{MN_SBC, AM_ABSY};
      8'hFD: e = '{MN_SBC, AM_ABSX};
      8'hFE: e = '{MN_INC, AM_ABSX};
      default: e = '{MN_ILL, AM_NONE};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: design/byte_stream_opcode_predecoder_top.sv
// Top level of the byte stream opcode predecoder.
// Depends on bsopd_pkg for the opcode table, code types and widths.
`default_nettype none

// Usage:
// Code bytes arrive on the in_ channel (valid/ready), one byte per request,
// with in_last marking the final byte of a block. Each complete instruction
// produces one decoded record on the out_ channel (valid/ready); a block that
// ends mid-instruction produces its record at once with missing bytes as zero
// and out_truncated set. Branches report their 16-bit target as the operand.
// cfg_wr_en/cfg_wr_data set the address of the first byte of each block; it
// is sampled when a block's first byte is accepted.
// A record is registered and appears in the cycle after the byte that
// completes it is accepted. Throughput: one byte per cycle while the
// receiver keeps up, set by the single output register stage; a byte that
// completes an instruction is taken while the previous record is being
// handed over. When the receiver stalls with a record pending, in_ready
// drops until that record is taken. Reset clears the decoder to await an
// opcode, clears the start address to zero and empties the output register.
module byte_stream_opcode_predecoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bsopd_pkg::ByteW-1:0]   in_data_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bsopd_pkg::AddrW-1:0]   out_instr_address,
  output logic      [bsopd_pkg::ByteW-1:0]   out_opcode,
  output logic      [bsopd_pkg::MnW-1:0]     out_mnemonic,
  output logic      [bsopd_pkg::ModeW-1:0]   out_mode,
  output logic      [bsopd_pkg::AddrW-1:0]   out_operand,
  output logic      [bsopd_pkg::LenW-1:0]    out_length,
  output logic                               out_truncated,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bsopd_pkg::AddrW-1:0]   cfg_wr_data
);
  import bsopd_pkg::*;

  logic [AddrW-1:0] start_addr_r;
  logic [AddrW-1:0] cur_addr_r;
  logic [AddrW-1:0] cur_addr_nxt;
  logic             in_block_r;
  logic             in_block_nxt;
  logic [AddrW-1:0] instr_start_r;
  logic [AddrW-1:0] instr_start_nxt;
  logic [ByteW-1:0] pend_op_r;
  logic [ByteW-1:0] pend_op_nxt;
  idx_t             idx_r;
  idx_t             idx_nxt;
  logic [ByteW-1:0] op_low_r;
  logic [ByteW-1:0] op_low_nxt;

  logic             out_valid_r;
  logic [AddrW-1:0] out_addr_r;
  logic [ByteW-1:0] out_op_r;
  mn_t              out_mn_r;
  am_t              out_am_r;
  logic [AddrW-1:0] out_operand_r;
  logic [LenW-1:0]  out_len_r;
  logic             out_trunc_r;

  logic             accept;
  logic [AddrW-1:0] byte_addr;
  logic             emit;
  logic             trunc;
  logic [AddrW-1:0] rec_addr;
  logic [ByteW-1:0] rec_op;
  logic [ByteW-1:0] b1;
  logic [ByteW-1:0] b2;
  op_info_t         info;
  logic [LenW-1:0]  rec_len;
  logic [AddrW-1:0] rec_operand;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign byte_addr = in_block_r ? cur_addr_r : start_addr_r;

  always_comb begin
    instr_start_nxt = instr_start_r;
    pend_op_nxt     = pend_op_r;
    op_low_nxt      = op_low_r;
    idx_nxt         = idx_r;
    emit            = 1'b0;
    trunc           = 1'b0;
    rec_addr        = instr_start_r;
    rec_op          = pend_op_r;
    b1              = '0;
    b2              = '0;
    unique case (idx_r)
      IDX_LOW: begin
        op_low_nxt = in_data_byte;
        b1         = in_data_byte;
        if (len_of(op_lookup(pend_op_r).am) == LEN_2) begin
          emit    = 1'b1;
          idx_nxt = IDX_OPCODE;
        end else if (in_last) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end else begin
          idx_nxt = IDX_HIGH;
        end
      end
      IDX_HIGH: begin
        emit    = 1'b1;
        b1      = op_low_r;
        b2      = in_data_byte;
        idx_nxt = IDX_OPCODE;
      end
      IDX_OPCODE, IDX_STRAY: begin
        instr_start_nxt = byte_addr;
        pend_op_nxt     = in_data_byte;
        rec_addr        = byte_addr;
        rec_op          = in_data_byte;
        if (len_of(op_lookup(in_data_byte).am) == LEN_1) begin
          emit    = 1'b1;
          idx_nxt = IDX_OPCODE;
        end else if (in_last) begin
          emit    = 1'b1;
          trunc   = 1'b1;
          idx_nxt = IDX_OPCODE;
        end else begin
          idx_nxt = IDX_LOW;
        end
      end
      default: begin
        idx_nxt = IDX_OPCODE;
      end
    endcase
    if (in_last) begin
      idx_nxt = IDX_OPCODE;
    end
    cur_addr_nxt = byte_addr + AddrW'(1);
    in_block_nxt = !in_last;
  end

  always_comb begin
    info    = op_lookup(rec_op);
    rec_len = len_of(info.am);
    if (rec_len == LEN_3) begin
      rec_operand = {b2, b1};
    end else if (rec_len == LEN_2 && info.am == AM_REL) begin
      rec_operand = rec_addr + AddrW'(2) + {{(AddrW-ByteW){b1[ByteW-1]}}, b1};
    end else if (rec_len == LEN_2) begin
      rec_operand = {{(AddrW-ByteW){1'b0}}, b1};
    end else begin
      rec_operand = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r  <= '0;
      cur_addr_r    <= '0;
      in_block_r    <= 1'b0;
      instr_start_r <= '0;
      pend_op_r     <= '0;
      idx_r         <= IDX_OPCODE;
      op_low_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_addr_r <= cfg_wr_data;
      end
      if (accept) begin
        cur_addr_r    <= cur_addr_nxt;
        in_block_r    <= in_block_nxt;
        instr_start_r <= instr_start_nxt;
        pend_op_r     <= pend_op_nxt;
        idx_r         <= idx_nxt;
        op_low_r      <= op_low_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_addr_r    <= rec_addr;
      out_op_r      <= rec_op;
      out_mn_r      <= info.mn;
      out_am_r      <= info.am;
      out_operand_r <= rec_operand;
      out_len_r     <= rec_len;
      out_trunc_r   <= trunc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_instr_address = out_addr_r;
  assign out_opcode        = out_op_r;
  assign out_mnemonic      = out_mn_r;
  assign out_mode          = out_am_r;
  assign out_operand       = out_operand_r;
  assign out_length        = out_len_r;
  assign out_truncated     = out_trunc_r;

endmodule

`default_nettype wire

FILE: dv/tb_byte_stream_opcode_predecoder_top.sv
`timescale 1ns / 100ps
// Testbench for byte_stream_opcode_predecoder_top: streams blocks of code bytes and checks
// every decoded record against a predictor with its own opcode decoder.
// Depends on bsopd_pkg and the design top level; needs nothing else.

module tb_byte_stream_opcode_predecoder_top;
  import bsopd_pkg::*;

  localparam int unsigned RandomBytes    = 800;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned LongHoldAt     = 40;
  localparam int unsigned LongHoldCycles = 150;

  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_CONFIG,
    FEED_DRAIN
  } feed_kind_t;

  typedef struct packed {
    feed_kind_t  kind;
    logic [7:0]  code;
    logic        is_last;
    logic [15:0] base;
  } feed_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    mn_t         mnemonic;
    am_t         mode;
    logic [15:0] operand;
    logic [1:0]  length;
    logic        truncated;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_instr_address;
  logic [7:0]  out_opcode;
  logic [5:0]  out_mnemonic;
  logic [3:0]  out_mode;
  logic [15:0] out_operand;
  logic [1:0]  out_length;
  logic        out_truncated;

  // Predictor state.
  logic [15:0] base_model = 16'h0000;
  logic [15:0] next_addr = 16'h0000;
  logic [15:0] instr_addr = 16'h0000;
  logic [7:0]  pend_op = 8'h00;
  logic [7:0]  op_low = 8'h00;
  idx_t        byte_pos = IDX_OPCODE;
  logic        in_block = 1'b0;

  decoded_t records_due[$];
  feed_t    code_feed[$];

  int mismatches = 0;
  int results_seen = 0;
  int bytes_planned = 0;
  int stall_cycles = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int feed_phase_left = 0;
  int sink_phase_left = 0;
  logic feed_calm = 1'b0;
  logic sink_calm = 1'b0;

  byte_stream_opcode_predecoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_instr_address (out_instr_address),
    .out_opcode        (out_opcode),
    .out_mnemonic      (out_mnemonic),
    .out_mode          (out_mode),
    .out_operand       (out_operand),
    .out_length        (out_length),
    .out_truncated     (out_truncated),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // The opcode is split into its aaa/bbb/cc fields and decoded by group.
  function automatic op_info_t op_decode(input logic [7:0] op);
    op_info_t e;
    mn_t row_mn;
    logic [2:0] aaa;
    logic [2:0] bbb;
    aaa = op[7:5];
    bbb = op[4:2];
    e = '{MN_ILL, AM_NONE};
    row_mn = MN_ILL;
    case (op[1:0])
      2'b01: begin
        case (aaa)
          3'd0: e.mn = MN_ORA;
          3'd1: e.mn = MN_AND;
          3'd2: e.mn = MN_EOR;
          3'd3: e.mn = MN_ADC;
          3'd4: e.mn = MN_STA;
          3'd5: e.mn = MN_LDA;
          3'd6: e.mn = MN_CMP;
          default: e.mn = MN_SBC;
        endcase
        case (bbb)
          3'd0: e.am = AM_INDX;
          3'd1: e.am = AM_ZP;
          3'd2: e.am = AM_IMM;
          3'd3: e.am = AM_ABS;
          3'd4: e.am = AM_INDY;
          3'd5: e.am = AM_ZPX;
          3'd6: e.am = AM_ABSY;
          default: e.am = AM_ABSX;
        endcase
        // There is no immediate store.
        if (aaa == 3'd4 && bbb == 3'd2) e = '{MN_ILL, AM_NONE};
      end
      2'b10: begin
        case (aaa)
          3'd0: row_mn = MN_ASL;
          3'd1: row_mn = MN_ROL;
          3'd2: row_mn = MN_LSR;
          3'd3: row_mn = MN_ROR;
          3'd4: row_mn = MN_STX;
          3'd5: row_mn = MN_LDX;
          3'd6: row_mn = MN_DEC;
          default: row_mn = MN_INC;
        endcase
        case (bbb)
          3'd0: if (aaa == 3'd5) e = '{row_mn, AM_IMM};
          3'd1: e = '{row_mn, AM_ZP};
          3'd2: begin
            case (aaa)
              3'd4: e = '{MN_TXA, AM_NONE};
              3'd5: e = '{MN_TAX, AM_NONE};
              3'd6: e = '{MN_DEX, AM_NONE};
              3'd7: e = '{MN_NOP, AM_NONE};
              default: e = '{row_mn, AM_ACC};
            endcase
          end
          3'd3: e = '{row_mn, AM_ABS};
          3'd5: begin
            if (aaa == 3'd4 || aaa == 3'd5) e = '{row_mn, AM_ZPY};
            else e = '{row_mn, AM_ZPX};
          end
          3'd6: begin
            if (aaa == 3'd4) e = '{MN_TXS, AM_NONE};
            else if (aaa == 3'd5) e = '{MN_TSX, AM_NONE};
          end
          3'd7: begin
            if (aaa == 3'd5) e = '{row_mn, AM_ABSY};
            else if (aaa != 3'd4) e = '{row_mn, AM_ABSX};
          end
          default: ;
        endcase
      end
      2'b00: begin
        case (bbb)
          3'd0: begin
            case (aaa)
              3'd0: e = '{MN_BRK, AM_NONE};
              3'd1: e = '{MN_JSR, AM_ABS};
              3'd2: e = '{MN_RTI, AM_NONE};
              3'd3: e = '{MN_RTS, AM_NONE};
              3'd5: e = '{MN_LDY, AM_IMM};
              3'd6: e = '{MN_CPY, AM_IMM};
              3'd7: e = '{MN_CPX, AM_IMM};
              default: ;
            endcase
          end
          3'd1: begin
            case (aaa)
              3'd1: e = '{MN_BIT, AM_ZP};
              3'd4: e = '{MN_STY, AM_ZP};
              3'd5: e = '{MN_LDY, AM_ZP};
              3'd6: e = '{MN_CPY, AM_ZP};
              3'd7: e = '{MN_CPX, AM_ZP};
              default: ;
            endcase
          end
          3'd2: begin
            case (aaa)
              3'd0: e = '{MN_PHP, AM_NONE};
              3'd1: e = '{MN_PLP, AM_NONE};
              3'd2: e = '{MN_PHA, AM_NONE};
              3'd3: e = '{MN_PLA, AM_NONE};
              3'd4: e = '{MN_DEY, AM_NONE};
              3'd5: e = '{MN_TAY, AM_NONE};
              3'd6: e = '{MN_INY, AM_NONE};
              default: e = '{MN_INX, AM_NONE};
            endcase
          end
          3'd3: begin
            case (aaa)
              3'd1: e = '{MN_BIT, AM_ABS};
              3'd2: e = '{MN_JMP, AM_ABS};
              3'd3: e = '{MN_JMP, AM_IND};
              3'd4: e = '{MN_STY, AM_ABS};
              3'd5: e = '{MN_LDY, AM_ABS};
              3'd6: e = '{MN_CPY, AM_ABS};
              3'd7: e = '{MN_CPX, AM_ABS};
              default: ;
            endcase
          end
          3'd4: begin
            case (aaa)
              3'd0: e = '{MN_BPL, AM_REL};
              3'd1: e = '{MN_BMI, AM_REL};
              3'd2: e = '{MN_BVC, AM_REL};
              3'd3: e = '{MN_BVS, AM_REL};
              3'd4: e = '{MN_BCC, AM_REL};
              3'd5: e = '{MN_BCS, AM_REL};
              3'd6: e = '{MN_BNE, AM_REL};
              default: e = '{MN_BEQ, AM_REL};
            endcase
          end
          3'd5: begin
            if (aaa == 3'd4) e = '{MN_STY, AM_ZPX};
            else if (aaa == 3'd5) e = '{MN_LDY, AM_ZPX};
          end
          3'd6: begin
            case (aaa)
              3'd0: e = '{MN_CLC, AM_NONE};
              3'd1: e = '{MN_SEC, AM_NONE};
              3'd2: e = '{MN_CLI, AM_NONE};
              3'd3: e = '{MN_SEI, AM_NONE};
              3'd4: e = '{MN_TYA, AM_NONE};
              3'd5: e = '{MN_CLV, AM_NONE};
              3'd6: e = '{MN_CLD, AM_NONE};
              default: e = '{MN_SED, AM_NONE};
            endcase
          end
          default: if (aaa == 3'd5) e = '{MN_LDY, AM_ABSX};
        endcase
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [1:0] op_length(input am_t am);
    logic [1:0] len;
    if (am < AM_IMM) len = LEN_1;
    else if (am < AM_ABS) len = LEN_2;
    else len = LEN_3;
    return len;
  endfunction

  function automatic decoded_t build_record(input logic [15:0] at, input logic [7:0] op,
                                            input logic [7:0] lo, input logic [7:0] hi,
                                            input logic cut);
    decoded_t r;
    op_info_t info;
    info = op_decode(op);
    r.instr_address = at;
    r.opcode = op;
    r.mnemonic = info.mn;
    r.mode = info.am;
    r.length = op_length(info.am);
    r.truncated = cut;
    if (r.length == LEN_3) r.operand = {hi, lo};
    else if (r.length == LEN_2 && info.am == AM_REL) r.operand = at + 16'd2 + {{8{lo[7]}}, lo};
    else if (r.length == LEN_2) r.operand = {8'h00, lo};
    else r.operand = 16'h0000;
    return r;
  endfunction

  function automatic void predecode_byte(input logic [7:0] code, input logic is_last);
    logic [15:0] addr;
    op_info_t info;
    addr = in_block ? next_addr : base_model;
    case (byte_pos)
      IDX_LOW: begin
        op_low = code;
        info = op_decode(pend_op);
        if (op_length(info.am) == LEN_2) begin
          records_due.insert(records_due.size(),
                             build_record(instr_addr, pend_op, code, 8'h00, 1'b0));
          byte_pos = IDX_OPCODE;
        end else if (is_last) begin
          records_due.insert(records_due.size(),
                             build_record(instr_addr, pend_op, code, 8'h00, 1'b1));
        end else begin
          byte_pos = IDX_HIGH;
        end
      end
      IDX_HIGH: begin
        records_due.insert(records_due.size(),
                           build_record(instr_addr, pend_op, op_low, code, 1'b0));
        byte_pos = IDX_OPCODE;
      end
      default: begin
        instr_addr = addr;
        pend_op = code;
        info = op_decode(code);
        if (op_length(info.am) == LEN_1) begin
          records_due.insert(records_due.size(),
                             build_record(addr, code, 8'h00, 8'h00, 1'b0));
          byte_pos = IDX_OPCODE;
        end else if (is_last) begin
          records_due.insert(records_due.size(),
                             build_record(addr, code, 8'h00, 8'h00, 1'b1));
          byte_pos = IDX_OPCODE;
        end else begin
          byte_pos = IDX_LOW;
        end
      end
    endcase
    next_addr = addr + 16'd1;
    if (is_last) begin
      byte_pos = IDX_OPCODE;
      in_block = 1'b0;
    end else begin
      in_block = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [15:0] pick_base();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = 16'hFFF0 | 16'($urandom_range(0, 15));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic push_byte(input logic [7:0] code, input logic is_last);
    feed_t f;
    f = '{FEED_BYTE, code, is_last, 16'h0000};
    code_feed.insert(code_feed.size(), f);
    bytes_planned++;
  endtask

  task automatic push_config(input logic [15:0] base);
    feed_t f;
    f = '{FEED_CONFIG, 8'h00, 1'b0, base};
    code_feed.insert(code_feed.size(), f);
  endtask

  task automatic push_drain();
    feed_t f;
    f = '{FEED_DRAIN, 8'h00, 1'b0, 16'h0000};
    code_feed.insert(code_feed.size(), f);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : feed_driver
    logic offering;
    logic nv;
    logic nl;
    logic nc;
    logic [7:0] nd;
    logic [15:0] nb;
    int r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_last <= 1'b0;
      cfg_wr_en <= 1'b0;
      cfg_wr_data <= 16'h0000;
    end else begin
      offering = in_valid && !in_ready;
      nv = offering;
      nd = in_data_byte;
      nl = in_last;
      nc = 1'b0;
      nb = cfg_wr_data;
      if (feed_phase_left == 0) begin
        feed_phase_left = $urandom_range(20, 100);
        feed_calm = ($urandom_range(0, 2) == 0);
      end else begin
        feed_phase_left--;
      end
      if (in_valid && in_ready) begin
        predecode_byte(in_data_byte, in_last);
        quiet_cycles = 0;
        r = $urandom_range(0, 99);
        if (feed_calm || r < 50) gap_left = 0;
        else if (r < 88) gap_left = $urandom_range(2, 4);
        else gap_left = $urandom_range(9, 31);
      end else if (quiet_cycles < SettleCycles) begin
        quiet_cycles++;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (code_feed.size() > 0) begin
          case (code_feed[0].kind)
            FEED_BYTE: begin
              nv = 1'b1;
              nd = code_feed[0].code;
              nl = code_feed[0].is_last;
              void'(code_feed.pop_front());
            end
            FEED_CONFIG: begin
              if (records_due.size() == 0 && quiet_cycles >= SettleCycles) begin
                nc = 1'b1;
                nb = code_feed[0].base;
                base_model = nb;
                void'(code_feed.pop_front());
              end
            end
            default: begin
              if (records_due.size() == 0) void'(code_feed.pop_front());
            end
          endcase
        end
      end
      in_valid <= nv;
      in_data_byte <= nd;
      in_last <= nl;
      cfg_wr_en <= nc;
      cfg_wr_data <= nb;
    end
  end

  always @(posedge clk) begin : result_monitor
    decoded_t want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (records_due.size() == 0) begin
          $error("record at address %0h arrived with no request pending", out_instr_address);
          mismatches++;
        end else begin
          want = records_due.pop_front();
          check_field("instr_address", want.instr_address, out_instr_address);
          check_field("opcode", want.opcode, out_opcode);
          check_field("mnemonic", want.mnemonic, out_mnemonic);
          check_field("mode", want.mode, out_mode);
          check_field("operand", want.operand, out_operand);
          check_field("length", want.length, out_length);
          check_field("truncated", want.truncated, out_truncated);
        end
        if (results_seen == LongHoldAt) hold_left = LongHoldCycles;
      end
      if (sink_phase_left == 0) begin
        sink_phase_left = $urandom_range(20, 100);
        sink_calm = ($urandom_range(0, 2) == 0);
      end else begin
        sink_phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if ($urandom_range(0, 299) == 0) hold_left = $urandom_range(20, 60);
        rdy = sink_calm || ($urandom_range(0, 99) < 65);
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_goal;
    int n_insn;
    int take;
    int pick;
    logic [7:0] op;
    logic [7:0] b;
    logic [1:0] len;
    logic cut;
    op_info_t info;

    // The first block runs from the reset start address.
    push_byte(8'hEA, 1'b1);
    push_config(16'hFFFF);
    push_byte(8'hD0, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    // A new start address written mid-block only applies to the next block.
    push_config(16'h1234);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h6C, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h4C, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'hF0, 1'b1);
    push_byte(8'h8D, 1'b1);
    push_config(16'h0000);
    push_drain();

    random_goal = bytes_planned + RandomBytes;
    while (bytes_planned < random_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        push_config(pick_base());
      end else if (pick < 10) begin
        push_drain();
      end else begin
        n_insn = $urandom_range(1, 8);
        cut = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n_insn; k++) begin
          if ($urandom_range(0, 99) < 12) begin
            op = 8'($urandom_range(0, 255));
          end else begin
            do begin
              op = 8'($urandom_range(0, 255));
              info = op_decode(op);
            end while (info.mn == MN_ILL);
          end
          info = op_decode(op);
          len = op_length(info.am);
          take = len;
          if (k == n_insn - 1 && cut && len > LEN_1) take = $urandom_range(1, len - 1);
          for (int j = 0; j < take; j++) begin
            if (j == 0) begin
              b = op;
            end else begin
              case ($urandom_range(0, 5))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h80;
                3: b = 8'h7F;
                default: b = 8'($urandom_range(0, 255));
              endcase
            end
            push_byte(b, (k == n_insn - 1) && (j == take - 1));
          end
          if (k < n_insn - 1 && $urandom_range(0, 49) == 0) push_config(pick_base());
        end
      end
    end
    push_config(16'hFFFF);
    push_drain();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (code_feed.size() != 0 || in_valid || records_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
